/* hdl/drbfs_pkg.sv */
// Shared constants, types and move tables of the domino robot grid search
package drbfs_pkg;

  localparam int unsigned DEF_MAX_SIDE = 128;
  localparam logic [7:0]  GRID_RESET   = 8'd128;
  localparam int unsigned STEPS_W      = 15;
  localparam logic [STEPS_W-1:0] STEP_SAT = 15'h7FFF;
  localparam int unsigned NUM_CAND     = 8;

  localparam logic signed [1:0] OFF_M1 = 2'sb11;
  localparam logic signed [1:0] OFF_Z  = 2'sb00;
  localparam logic signed [1:0] OFF_P1 = 2'sb01;

  // Offsets of one candidate move relative to the popped anchor
  typedef struct packed {
    logic              rot;
    logic signed [1:0] adr;
    logic signed [1:0] adc;
    logic signed [1:0] cdr;
    logic signed [1:0] cdc;
  } cand_off_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic clr;
    logic init;
    logic pop;
    logic fetch;
    logic goal;
    logic c0;
    logic c1;
    logic c2;
    logic c3;
    logic c4;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_last;
    logic q_empty;
    logic is_goal;
    logic k_last;
  } sts_t;

  // Candidates 0..3 translate, 4..7 pivot into the other orientation
  function automatic cand_off_t cand_off(input logic d, input logic [2:0] k);
    cand_off_t o;
    o = '{rot: 1'b0, adr: OFF_Z, adc: OFF_Z, cdr: OFF_Z, cdc: OFF_Z};
    unique case (k)
      3'd0: o.adr = OFF_M1;
      3'd1: o.adr = OFF_P1;
      3'd2: o.adc = OFF_M1;
      3'd3: o.adc = OFF_P1;
      3'd4: begin
        o.rot = 1'b1;
        if (!d) begin
          o.adr = OFF_M1; o.cdr = OFF_M1; o.cdc = OFF_P1;
        end else begin
          o.adc = OFF_M1; o.cdr = OFF_P1; o.cdc = OFF_M1;
        end
      end
      3'd5: begin
        o.rot = 1'b1;
        o.cdr = OFF_P1; o.cdc = OFF_P1;
      end
      3'd6: begin
        o.rot = 1'b1;
        if (!d) begin
          o.adr = OFF_M1; o.adc = OFF_P1; o.cdr = OFF_M1;
        end else begin
          o.adr = OFF_P1; o.adc = OFF_M1; o.cdc = OFF_M1;
        end
      end
      default: begin
        o.rot = 1'b1;
        if (!d) begin
          o.adc = OFF_P1; o.cdr = OFF_P1;
        end else begin
          o.adr = OFF_P1; o.cdc = OFF_P1;
        end
      end
    endcase
    return o;
  endfunction

endpackage

/* hdl/drbfs_ctrl.sv */
// Sequencing state machine for wall loading and the breadth-first search
module drbfs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              last_cell_i,
  input  drbfs_pkg::sts_t   sts_i,
  output drbfs_pkg::cmd_t   cmd_o,
  output logic              busy,
  output logic              done_o
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_CLEAR = 12'b000000000010,
    S_INIT  = 12'b000000000100,
    S_POP   = 12'b000000001000,
    S_FETCH = 12'b000000010000,
    S_GOAL  = 12'b000000100000,
    S_C0    = 12'b000001000000,
    S_C1    = 12'b000010000000,
    S_C2    = 12'b000100000000,
    S_C3    = 12'b001000000000,
    S_C4    = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load = start;
        if (start && last_cell_i) state_d = S_CLEAR;
      end
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) state_d = S_INIT;
      end
      S_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = S_POP;
      end
      S_POP: begin
        cmd_o.pop = 1'b1;
        state_d   = sts_i.q_empty ? S_DONE : S_FETCH;
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = S_GOAL;
      end
      S_GOAL: begin
        cmd_o.goal = 1'b1;
        state_d    = sts_i.is_goal ? S_DONE : S_C0;
      end
      S_C0: begin
        cmd_o.c0 = 1'b1;
        state_d  = S_C1;
      end
      S_C1: begin
        cmd_o.c1 = 1'b1;
        state_d  = S_C2;
      end
      S_C2: begin
        cmd_o.c2 = 1'b1;
        state_d  = S_C3;
      end
      S_C3: begin
        cmd_o.c3 = 1'b1;
        state_d  = S_C4;
      end
      S_C4: begin
        cmd_o.c4 = 1'b1;
        state_d  = sts_i.k_last ? S_POP : S_C0;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

/* hdl/drbfs_dp.sv */
// Wall map, visited map, step store, frontier queue and move evaluation
module drbfs_dp #(
  parameter int unsigned MAX_SIDE = drbfs_pkg::DEF_MAX_SIDE
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  drbfs_pkg::cmd_t               cmd_i,
  output drbfs_pkg::sts_t               sts_o,
  input  logic                          cell_blocked_i,
  input  logic                          cfg_valid_i,
  input  logic [7:0]                    cfg_data_i,
  output logic [drbfs_pkg::STEPS_W-1:0] min_steps_o,
  output logic                          goal_reached_o
);

  localparam int unsigned CW   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int unsigned NW   = $clog2(MAX_SIDE + 1);
  localparam int unsigned SW   = CW + 2;
  localparam int unsigned AW   = 2 * CW;
  localparam int unsigned IW   = AW + 1;
  localparam int unsigned TW   = IW + 1;
  localparam int unsigned STW  = IW + 1;
  localparam int unsigned RW   = (STW > drbfs_pkg::STEPS_W) ? STW : drbfs_pkg::STEPS_W;
  localparam int unsigned WDEP = 2 ** AW;
  localparam int unsigned SDEP = 2 ** IW;

  logic                 wall_mem [WDEP];
  logic                 vis_mem  [SDEP];
  logic [STW-1:0]       step_mem [SDEP];
  logic [IW-1:0]        que_mem  [SDEP];

  logic [7:0]           grid_q;
  logic [NW-1:0]        ld_r_q, ld_c_q;
  logic [IW-1:0]        clr_q;
  logic [TW-1:0]        head_q, tail_q;
  logic [CW-1:0]        r_q, c_q;
  logic                 d_q;
  logic [STW-1:0]       step_q;
  logic [2:0]           k_q;
  logic                 ok_q;
  logic                 inb_q;
  logic                 wall_rd_q;
  logic                 vis_rd_q;
  logic [STW-1:0]       step_rd_q;
  logic [IW-1:0]        que_rd_q;
  logic [drbfs_pkg::STEPS_W-1:0] res_steps_q;
  logic                 res_ok_q;

  logic [NW-1:0]        n;
  logic signed [SW-1:0] ns, rs, cs, ar, ac, er, ec, cr, cc;
  logic                 nd;
  drbfs_pkg::cand_off_t off;
  logic                 in_a, in_e, in_c;
  logic [AW-1:0]        wall_ra;
  logic                 wall_rinb;
  logic [IW-1:0]        new_id;
  logic                 enter;
  logic [RW-1:0]        step_ext;

  // Side length in use, held to the legal range
  always_comb begin
    if (grid_q < 8'd2) begin
      n = NW'(2);
    end else if ({1'b0, grid_q} > 9'(MAX_SIDE)) begin
      n = NW'(MAX_SIDE);
    end else begin
      n = NW'(grid_q);
    end
  end

  assign ns  = SW'(n);
  assign rs  = $signed({2'b00, r_q});
  assign cs  = $signed({2'b00, c_q});
  assign off = drbfs_pkg::cand_off(d_q, k_q);
  assign nd  = off.rot ? ~d_q : d_q;
  assign ar  = rs + SW'(off.adr);
  assign ac  = cs + SW'(off.adc);
  assign er  = ar + (nd ? SW'(1) : SW'(0));
  assign ec  = ac + (nd ? SW'(0) : SW'(1));
  assign cr  = rs + SW'(off.cdr);
  assign cc  = cs + SW'(off.cdc);

  assign in_a = (ar >= 0) && (ar < ns) && (ac >= 0) && (ac < ns);
  assign in_e = (er >= 0) && (er < ns) && (ec >= 0) && (ec < ns);
  assign in_c = (cr >= 0) && (cr < ns) && (cc >= 0) && (cc < ns);

  // Pick the cell under test for this phase of the candidate
  always_comb begin
    if (cmd_i.c0 && off.rot) begin
      wall_ra   = {cr[CW-1:0], cc[CW-1:0]};
      wall_rinb = in_c;
    end else if (cmd_i.c2) begin
      wall_ra   = {er[CW-1:0], ec[CW-1:0]};
      wall_rinb = in_e;
    end else begin
      wall_ra   = {ar[CW-1:0], ac[CW-1:0]};
      wall_rinb = in_a;
    end
  end

  assign new_id = {ar[CW-1:0], ac[CW-1:0], nd};
  assign enter  = cmd_i.c4 && ok_q && !vis_rd_q;

  assign sts_o.clr_last = &clr_q;
  assign sts_o.q_empty  = (head_q == tail_q);
  assign sts_o.is_goal  = ( d_q && (SW'(r_q) == ns - SW'(2)) && (SW'(c_q) == ns - SW'(1))) ||
                          (!d_q && (SW'(r_q) == ns - SW'(1)) && (SW'(c_q) == ns - SW'(2)));
  assign sts_o.k_last   = (k_q == 3'(drbfs_pkg::NUM_CAND - 1));

  assign step_ext = RW'(step_rd_q);

  // Memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (ld_r_q < n)) begin
      wall_mem[{ld_r_q[CW-1:0], ld_c_q[CW-1:0]}] <= cell_blocked_i;
    end
    wall_rd_q <= wall_mem[wall_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      vis_mem[clr_q] <= 1'b0;
    end else if (cmd_i.init) begin
      vis_mem[IW'(0)] <= 1'b1;
    end else if (enter) begin
      vis_mem[new_id] <= 1'b1;
    end
    vis_rd_q <= vis_mem[new_id];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      step_mem[IW'(0)] <= '0;
    end else if (enter) begin
      step_mem[new_id] <= step_q + STW'(1);
    end
    step_rd_q <= step_mem[que_rd_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      que_mem[IW'(0)] <= '0;
    end else if (enter) begin
      que_mem[tail_q[IW-1:0]] <= new_id;
    end
    que_rd_q <= que_mem[head_q[IW-1:0]];
  end

  // Payload registers of the current search
  always_ff @(posedge clk_i) begin
    inb_q <= wall_rinb;
    if (cmd_i.fetch) begin
      {r_q, c_q, d_q} <= que_rd_q;
    end
    if (cmd_i.goal) begin
      step_q <= step_rd_q;
    end
    if (cmd_i.c0) begin
      ok_q <= 1'b1;
    end else if (cmd_i.c1 && off.rot) begin
      ok_q <= ok_q && inb_q && !wall_rd_q;
    end else if (cmd_i.c2 || cmd_i.c3) begin
      ok_q <= ok_q && inb_q && !wall_rd_q;
    end
  end

  // Control counters and the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q      <= drbfs_pkg::GRID_RESET;
      ld_r_q      <= '0;
      ld_c_q      <= '0;
      clr_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      k_q         <= '0;
      res_steps_q <= '0;
      res_ok_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) grid_q <= cfg_data_i;
      if (cmd_i.load) begin
        if (cmd_i.fetch) begin
          ld_r_q <= '0;
        end else if (ld_r_q < n) begin
          if (ld_c_q == n - NW'(1)) begin
            ld_c_q <= '0;
            ld_r_q <= ld_r_q + NW'(1);
          end else begin
            ld_c_q <= ld_c_q + NW'(1);
          end
        end
      end
      if (cmd_i.clr) begin
        clr_q  <= clr_q + IW'(1);
        ld_r_q <= '0;
        ld_c_q <= '0;
      end
      if (cmd_i.init) begin
        head_q <= '0;
        tail_q <= TW'(1);
      end
      if (cmd_i.pop) begin
        if (head_q == tail_q) begin
          res_steps_q <= '0;
          res_ok_q    <= 1'b0;
        end else begin
          head_q <= head_q + TW'(1);
        end
      end
      if (cmd_i.goal) begin
        k_q <= '0;
        if (sts_o.is_goal) begin
          res_ok_q    <= 1'b1;
          res_steps_q <= (step_ext > RW'(drbfs_pkg::STEP_SAT)) ? drbfs_pkg::STEP_SAT
                                                               : step_ext[drbfs_pkg::STEPS_W-1:0];
        end
      end
      if (cmd_i.c4) begin
        k_q <= k_q + 3'd1;
      end
      if (enter) begin
        tail_q <= tail_q + TW'(1);
      end
    end
  end

  assign min_steps_o    = res_steps_q;
  assign goal_reached_o = res_ok_q;

endmodule

/* hdl/domino_robot_grid_bfs_core.sv */
// Top level of the domino robot grid shortest-path search
//
// Grid cells are taken one per cycle in row-major order while start is high
// and busy is low; the cell flagged last_cell_i starts a search and raises
// busy. A search first clears the visited map of 2*2^(2*ceil(log2 MAX_SIDE))
// entries (32768 at the default), one entry a cycle, then for each popped
// robot state runs the pop, fetch and goal check steps and the C0 to C4 steps
// for each of its eight candidate moves, reading the wall map once per cell
// checked. The result is shown on min_steps_o and goal_reached_o for exactly
// one cycle with done_o high and must be taken then; busy drops in the
// following cycle. The grid size register may be written whenever busy is low.
module domino_robot_grid_bfs_core #(
  parameter int unsigned MAX_SIDE = drbfs_pkg::DEF_MAX_SIDE
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cell_blocked_i,
  input  logic                          last_cell_i,
  output logic                          done_o,
  output logic [drbfs_pkg::STEPS_W-1:0] min_steps_o,
  output logic                          goal_reached_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [7:0]                    cfg_data_i
);

  drbfs_pkg::cmd_t cmd;
  drbfs_pkg::sts_t sts;
  logic            cfg_wr;

  // Hold configuration off while a search runs
  assign cfg_ready_o = !busy;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  drbfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .last_cell_i (last_cell_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy        (busy),
    .done_o      (done_o)
  );

  drbfs_dp #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cell_blocked_i (cell_blocked_i),
    .cfg_valid_i    (cfg_wr),
    .cfg_data_i     (cfg_data_i),
    .min_steps_o    (min_steps_o),
    .goal_reached_o (goal_reached_o)
  );

endmodule
